// ===== sv/rss_pkg.sv =====
// package for the ramp/soak profile sequencer: request codes, fsm states
// no dependencies
`default_nettype none
package rss_pkg;
	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_START  = 3'd1,
		REQ_STOP   = 3'd2,
		REQ_PAUSE  = 3'd3,
		REQ_RESUME = 3'd4,
		REQ_WRITE  = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_NEXT,
		ST_INTERP,
		ST_DIV,
		ST_FINISH,
		ST_OUT
	} state_t;

	localparam logic [31:0] END_OF_TIME = 32'hFFFF_FFFF;
	localparam int ENTRY_W = 11 + 1 + 32 + 32;
endpackage
`default_nettype wire

// ===== sv/rss_if.sv =====
// valid/ready channel interfaces for the sequencer request and result words
// depends on nothing
`default_nettype none
interface rss_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [31:0] now_ms;
	logic signed [15:0] measured_temp;
	logic [3:0]  entry_index;
	logic [10:0] entry_target;
	logic        entry_fast;
	logic [31:0] entry_ramp_ms;
	logic [31:0] entry_dwell_ms;
	modport source (output valid, req_type, now_ms, measured_temp, entry_index,
		entry_target, entry_fast, entry_ramp_ms, entry_dwell_ms, input ready);
	modport sink (input valid, req_type, now_ms, measured_temp, entry_index,
		entry_target, entry_fast, entry_ramp_ms, entry_dwell_ms, output ready);
endinterface

interface rss_res_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] setpoint;
	logic        setpoint_valid;
	logic        heater_enable;
	logic        is_running;
	logic        is_paused;
	logic [3:0]  step_now;
	logic        in_soak;
	logic        program_done;
	modport source (output valid, setpoint, setpoint_valid, heater_enable, is_running,
		is_paused, step_now, in_soak, program_done, input ready);
	modport sink (input valid, setpoint, setpoint_valid, heater_enable, is_running,
		is_paused, step_now, in_soak, program_done, output ready);
endinterface
`default_nettype wire

// ===== sv/rss_ram.sv =====
// generic single-port-write, one-read ram with registered read data
// no dependencies
`default_nettype none
module rss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/ramp_soak_profile_sequencer.sv =====
// ramp/soak setpoint sequencer top level: request fsm, step table ram, serial divider
// depends on rss_pkg, rss_if, rss_ram
// control and write words pass READ and FINISH before the result; tick words pass READ,
// EVAL, NEXT, INTERP and FINISH, plus DIV when a ramp step interpolates (one quotient
// bit per cycle of a 48-bit restoring divider). one word at a time: the next word is
// taken in the cycle after the result word leaves. reset clears run state, step count
// to 1; the step table is undefined until written.
`default_nettype none
module ramp_soak_profile_sequencer #(
	parameter int MAX_STEPS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_wdata,
	rss_req_if.sink         req,
	rss_res_if.source       res
);
	import rss_pkg::*;

	localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int CW = IW + 1;

	state_t state_q, state_d;

	logic [4:0]  count_q;
	logic        running_q, paused_q, dwell_q, heading_q;
	logic [IW-1:0] step_q;
	logic [31:0] start_time_q, deadline_q;
	logic signed [15:0] start_temp_q;

	// latched request
	logic [2:0]  req_q;
	logic [31:0] now_q;
	logic signed [15:0] temp_q;

	// result
	logic signed [15:0] sp_q;
	logic        spv_q, done_q, out_valid_q;

	// table entry read
	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [10:0]   prev_tgt_q;

	// divider
	logic [47:0] quo_q, rem_q, dvd_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        neg_q;

	logic [IW-1:0] step_next;

	rss_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << IW)) u_tab (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic [10:0] e_tgt;
	logic        e_fast;
	logic [31:0] e_ramp, e_dwell;
	assign {e_tgt, e_fast, e_ramp, e_dwell} = ram_rdata;

	logic [CW-1:0] eff_cnt;
	always_comb begin
		if (32'(count_q) > 32'(MAX_STEPS))
			eff_cnt = CW'(MAX_STEPS);
		else
			eff_cnt = CW'(count_q);
	end

	logic signed [15:0] tgt_q4;
	assign tgt_q4 = signed'({1'b0, e_tgt, 4'b0});

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c);
		logic [33:0] s;
		s = 34'(a) + 34'(b) + 34'(c);
		return (s > 34'(END_OF_TIME)) ? END_OF_TIME : s[31:0];
	endfunction

	assign ram_we    = req.valid && req.ready && req.req_type == REQ_WRITE
		&& 32'(req.entry_index) < 32'(MAX_STEPS);
	assign ram_waddr = IW'(req.entry_index);
	assign ram_wdata = {req.entry_target, req.entry_fast, req.entry_ramp_ms,
		req.entry_dwell_ms};
	assign req.ready = (state_q == ST_IDLE);

	assign step_next = step_q + IW'(1);

	logic adv_q;

	always_comb begin
		ram_raddr = step_q;
		if (state_q == ST_IDLE && req.req_type == REQ_START)
			ram_raddr = '0;
		else if (state_q == ST_EVAL || (state_q == ST_NEXT && adv_q))
			ram_raddr = step_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd1;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	logic [47:0] rem_try;
	assign rem_try = {rem_q[46:0], dvd_q[47]};

	logic signed [16:0] diff;
	logic [31:0] elapsed;
	assign diff    = 17'(tgt_q4) - 17'(start_temp_q);
	assign elapsed = now_q - start_time_q;

	logic met;
	assign met = heading_q ? (temp_q > tgt_q4) : (temp_q < tgt_q4);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (req.valid) state_d = ST_READ;
			ST_READ:   state_d = (req_q == REQ_TICK) ? ST_EVAL : ST_FINISH;
			ST_EVAL:   state_d = ST_NEXT;
			ST_NEXT:   state_d = ST_INTERP;
			ST_INTERP: state_d = ST_FINISH;
			ST_DIV:    if (cnt_q == 6'd0) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT:    if (res.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
		if (state_q == ST_INTERP && running_q && !paused_q && !dwell_q && !spv_q && !e_fast
			&& e_ramp != 32'd0 && elapsed < e_ramp)
			state_d = ST_DIV;
	end

	// tick flow: EVAL runs crossing and due checks, NEXT commits step advance
	// using the next entry read in EVAL, INTERP sets the setpoint or starts division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0; paused_q <= 1'b0; dwell_q <= 1'b0; heading_q <= 1'b1;
			step_q <= '0; start_time_q <= '0; start_temp_q <= '0; deadline_q <= '0;
			out_valid_q <= 1'b0; spv_q <= 1'b0; done_q <= 1'b0; adv_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						req_q <= req.req_type; now_q <= req.now_ms;
						temp_q <= req.measured_temp;
						spv_q <= 1'b0; done_q <= 1'b0; sp_q <= '0; adv_q <= 1'b0;
					end
				end
				ST_READ: begin
					priority case (req_q)
						REQ_TICK: begin
							if (running_q && {1'b0, step_q} >= {1'b0, eff_cnt[CW-1:0]}
								|| running_q && CW'(step_q) >= eff_cnt) begin
								running_q <= 1'b0; paused_q <= 1'b0; step_q <= '0;
								dwell_q <= 1'b0; heading_q <= 1'b1; start_time_q <= now_q;
							end
						end
						REQ_START: if (!running_q) begin
							running_q <= 1'b1; paused_q <= 1'b0; step_q <= '0;
							dwell_q <= 1'b0; heading_q <= 1'b1; start_time_q <= now_q;
							start_temp_q <= temp_q;
							deadline_q <= sat_add(now_q, e_ramp, e_dwell);
						end
						REQ_STOP: if (running_q) begin
							running_q <= 1'b0; paused_q <= 1'b0; step_q <= '0;
							dwell_q <= 1'b0; heading_q <= 1'b1; start_time_q <= now_q;
						end
						REQ_PAUSE:  if (running_q) paused_q <= 1'b1;
						REQ_RESUME: if (running_q) paused_q <= 1'b0;
						default: ;
					endcase
				end
				ST_EVAL: begin
					prev_tgt_q <= e_tgt;
					if (running_q && !paused_q) begin
						if (!dwell_q && e_fast && met && e_dwell != 32'd0) begin
							deadline_q <= sat_add(now_q, e_dwell, 32'd0);
							dwell_q <= 1'b1; sp_q <= tgt_q4; spv_q <= 1'b1;
							// due against the fresh dwell deadline
							if (now_q >= sat_add(now_q, e_dwell, 32'd0)) adv_q <= 1'b1;
						end else if (now_q >= deadline_q || (!dwell_q && e_fast && met)) begin
							adv_q <= 1'b1;
						end
					end
				end
				ST_NEXT: begin
					if (adv_q) begin
						if (CW'(step_q) + CW'(1) >= eff_cnt) begin
							running_q <= 1'b0; paused_q <= 1'b0; step_q <= '0;
							dwell_q <= 1'b0; heading_q <= 1'b1; start_time_q <= now_q;
							done_q <= 1'b1; spv_q <= 1'b0; sp_q <= '0;
						end else begin
							step_q <= step_next; dwell_q <= 1'b0;
							heading_q <= e_fast ? (e_tgt > prev_tgt_q) : 1'b1;
							start_time_q <= now_q; start_temp_q <= temp_q; spv_q <= 1'b0;
							if (e_fast) begin
								deadline_q <= END_OF_TIME;
							end else begin
								deadline_q <= sat_add(now_q, e_ramp, e_dwell);
							end
						end
					end
				end
				ST_INTERP: begin
					// ram now holds the current step entry
					if (running_q && !paused_q && req_q == REQ_TICK && !dwell_q) begin
						if (e_fast || e_ramp == 32'd0 || elapsed >= e_ramp) begin
							spv_q <= 1'b1;
							sp_q <= tgt_q4;
						end else begin
							neg_q <= diff[16];
							dvd_q <= 48'(diff[16] ? 17'(-diff) : diff) * 48'(elapsed);
							dvs_q <= e_ramp; rem_q <= '0; quo_q <= '0; cnt_q <= 6'd47;
						end
					end
				end
				ST_DIV: begin
					dvd_q <= {dvd_q[46:0], 1'b0};
					if (rem_try >= 48'(dvs_q)) begin
						rem_q <= rem_try - 48'(dvs_q);
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						rem_q <= rem_try;
						quo_q <= {quo_q[46:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) adv_q <= 1'b1;
				end
				ST_FINISH: begin
					out_valid_q <= 1'b1;
					if (state_d == ST_OUT && adv_q && !spv_q && running_q && !dwell_q
						&& req_q == REQ_TICK && !done_q) begin
						spv_q <= 1'b1;
						sp_q  <= neg_q ? start_temp_q - quo_q[15:0] : start_temp_q + quo_q[15:0];
					end
				end
				ST_OUT: if (res.ready) out_valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// marks the divider result path; cleared on entry to a word
	logic div_used_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_used_q <= 1'b0;
		else if (state_q == ST_IDLE)
			div_used_q <= 1'b0;
		else if (state_q == ST_DIV)
			div_used_q <= 1'b1;
	end

	logic signed [15:0] sp_out;
	assign sp_out = (div_used_q && state_q == ST_OUT && !spv_q) ?
		(neg_q ? start_temp_q - quo_q[15:0] : start_temp_q + quo_q[15:0]) : sp_q;

	assign res.valid          = (state_q == ST_OUT) && out_valid_q;
	assign res.setpoint       = sp_out;
	assign res.setpoint_valid = spv_q || (div_used_q && state_q == ST_OUT);
	assign res.heater_enable  = running_q;
	assign res.is_running     = running_q;
	assign res.is_paused      = paused_q;
	assign res.step_now       = 4'(step_q);
	assign res.in_soak        = dwell_q;
	assign res.program_done   = done_q;
endmodule
`default_nettype wire

// ===== tb/sv/ramp_soak_profile_sequencer_checker.sv =====
// result checker for the ramp/soak sequencer: watches the request, result and config
// ports, predicts each result word and compares it; depends on rss_pkg, rss_if
`default_nettype none
module ramp_soak_profile_sequencer_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_wdata,
	rss_req_if              req,
	rss_res_if              res,
	output int              errors,
	output int              pending
);
	import rss_pkg::*;

	typedef struct packed {
		logic signed [15:0] setpoint;
		logic               sp_valid;
		logic               running;
		logic               paused;
		logic [3:0]         step;
		logic               soak;
		logic               done;
	} status_t;

	status_t status_q[$];

	logic [10:0] tgt_tab[16];
	bit          fast_tab[16];
	logic [31:0] ramp_tab[16];
	logic [31:0] dwell_tab[16];
	logic [4:0]  n_steps;
	bit          running, paused, soaking, rising;
	int          step;
	logic [31:0] t0, deadline;
	int          temp0;

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? END_OF_TIME : s[31:0];
	endfunction

	function automatic int live_steps();
		return (n_steps > 16) ? 16 : int'(n_steps);
	endfunction

	function automatic void halt_run(input logic [31:0] now);
		running = 0;
		paused = 0;
		step = 0;
		soaking = 0;
		rising = 1;
		t0 = now;
	endfunction

	function automatic int ramp_point(input logic [31:0] now);
		int tgt;
		logic [31:0] elapsed;
		longint diff;
		longint unsigned mag, off;
		tgt = int'(tgt_tab[step]) * 16;
		elapsed = now - t0;
		if (fast_tab[step] || ramp_tab[step] == 0 || elapsed >= ramp_tab[step])
			return tgt;
		diff = longint'(tgt) - longint'(temp0);
		mag = (diff < 0) ? longint'(-diff) : diff;
		off = mag * elapsed / ramp_tab[step];
		return (diff < 0) ? temp0 - int'(off) : temp0 + int'(off);
	endfunction

	function automatic status_t next_status(input logic [2:0] kind, input logic [31:0] now,
			input logic signed [15:0] temp, input logic [3:0] idx, input logic [10:0] tgt_w,
			input logic fast_w, input logic [31:0] ramp_w, input logic [31:0] dwell_w);
		status_t r;
		int sp, tgt;
		bit spv, done, met;
		sp = 0;
		spv = 0;
		done = 0;
		case (kind)
			REQ_TICK: begin
				if (running && step >= live_steps())
					halt_run(now);
				if (running && !paused) begin
					met = 0;
					if (!soaking && fast_tab[step]) begin
						tgt = int'(tgt_tab[step]) * 16;
						met = rising ? (int'(temp) > tgt) : (int'(temp) < tgt);
						if (met && dwell_tab[step] != 0) begin
							deadline = sat_sum(now, dwell_tab[step]);
							soaking = 1;
							met = 0;
							sp = tgt;
							spv = 1;
						end
					end
					if (now >= deadline || met) begin
						if (step + 1 >= live_steps()) begin
							halt_run(now);
							done = 1;
							spv = 0;
							sp = 0;
						end else begin
							step++;
							rising = 1;
							soaking = 0;
							t0 = now;
							temp0 = int'(temp);
							if (fast_tab[step]) begin
								deadline = END_OF_TIME;
								rising = tgt_tab[step] > tgt_tab[step - 1];
							end else begin
								deadline = sat_sum(now, sat_sum(ramp_tab[step], 0) + 0);
								deadline = sat_sum(sat_sum(now, ramp_tab[step]), 0);
								if ({1'b0, now} + ramp_tab[step] + dwell_tab[step] > 33'h0_FFFF_FFFF
										|| ({2'b0, now} + ramp_tab[step] + dwell_tab[step])
										> 34'h0_FFFF_FFFF)
									deadline = END_OF_TIME;
								else
									deadline = now + ramp_tab[step] + dwell_tab[step];
							end
						end
					end
					if (running && !soaking) begin
						sp = ramp_point(now);
						spv = 1;
					end
				end
			end
			REQ_START: begin
				if (!running) begin
					halt_run(now);
					running = 1;
					temp0 = int'(temp);
					if (({2'b0, now} + ramp_tab[0] + dwell_tab[0]) > 34'h0_FFFF_FFFF)
						deadline = END_OF_TIME;
					else
						deadline = now + ramp_tab[0] + dwell_tab[0];
				end
			end
			REQ_STOP: if (running) halt_run(now);
			REQ_PAUSE: if (running) paused = 1;
			REQ_RESUME: if (running) paused = 0;
			REQ_WRITE: begin
				tgt_tab[idx] = tgt_w;
				fast_tab[idx] = fast_w;
				ramp_tab[idx] = ramp_w;
				dwell_tab[idx] = dwell_w;
			end
			default: ;
		endcase
		r.setpoint = sp[15:0];
		r.sp_valid = spv;
		r.running = running;
		r.paused = paused;
		r.step = step[3:0];
		r.soak = soaking;
		r.done = done;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_t e;
		if (!arst_n) begin
			status_q.delete();
			errors <= 0;
			pending <= 0;
			n_steps = 5'd1;
			halt_run(0);
			temp0 = 0;
			deadline = 0;
		end else begin
			if (cfg_we)
				n_steps = cfg_wdata;
			if (req.valid && req.ready)
				status_q.push_back(next_status(req.req_type, req.now_ms, req.measured_temp,
					req.entry_index, req.entry_target, req.entry_fast, req.entry_ramp_ms,
					req.entry_dwell_ms));
			if (res.valid && res.ready) begin
				if (status_q.size() == 0) begin
					$error("result word with no request outstanding");
					errors <= errors + 1;
				end else begin
					e = status_q.pop_front();
					if (res.setpoint !== e.setpoint ||
							res.setpoint_valid !== e.sp_valid ||
							res.heater_enable !== e.running || res.is_running !== e.running ||
							res.is_paused !== e.paused || res.step_now !== e.step ||
							res.in_soak !== e.soak || res.program_done !== e.done)
						errors <= errors + 1;
					if (res.setpoint !== e.setpoint)
						$error("setpoint expected %0d got %0d", e.setpoint, res.setpoint);
					if (res.setpoint_valid !== e.sp_valid)
						$error("setpoint_valid expected %0b got %0b", e.sp_valid,
							res.setpoint_valid);
					if (res.heater_enable !== e.running)
						$error("heater_enable expected %0b got %0b", e.running,
							res.heater_enable);
					if (res.is_running !== e.running)
						$error("is_running expected %0b got %0b", e.running, res.is_running);
					if (res.is_paused !== e.paused)
						$error("is_paused expected %0b got %0b", e.paused, res.is_paused);
					if (res.step_now !== e.step)
						$error("step_now expected %0d got %0d", e.step, res.step_now);
					if (res.in_soak !== e.soak)
						$error("in_soak expected %0b got %0b", e.soak, res.in_soak);
					if (res.program_done !== e.done)
						$error("program_done expected %0b got %0b", e.done, res.program_done);
				end
			end
			pending <= status_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/ramp_soak_profile_sequencer_test.sv =====
// testbench top for the ramp/soak sequencer: clock, reset, request stimulus,
// result back-pressure and verdict; depends on rss_pkg, rss_if and the checker
`default_nettype none
module ramp_soak_profile_sequencer_test;
	import rss_pkg::*;

	localparam int ITEM_GOAL = 1700;
	localparam int CYCLE_LIMIT = 2000000;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_we = 0;
	logic [4:0] cfg_wdata = 5'd1;
	int         errors, pending;
	int         cycles = 0;
	int         sent = 0;
	bit         long_hold = 0;
	logic [31:0] clock_ms = 0;

	rss_req_if req ();
	rss_res_if res ();

	ramp_soak_profile_sequencer u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .res(res)
	);

	ramp_soak_profile_sequencer_checker u_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .res(res), .errors(errors), .pending(pending)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("ramp_soak_profile_sequencer verification failed");
			$finish;
		end
	end

	initial begin
		req.valid = 0;
		req.req_type = REQ_TICK;
		req.now_ms = 0;
		req.measured_temp = 0;
		req.entry_index = 0;
		req.entry_target = 0;
		req.entry_fast = 0;
		req.entry_ramp_ms = 0;
		req.entry_dwell_ms = 0;
		res.ready = 0;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if ($urandom_range(0, 5) == 0) n = 0;
			if (long_hold) begin
				long_hold = 0;
				n = 400;
			end
			if (n > 0) begin
				res.ready <= 0;
				repeat (n) @(posedge clk);
			end
			res.ready <= 1;
			do @(posedge clk); while (!res.valid);
		end
	end

	task automatic send(input req_t kind, input logic [31:0] now,
			input logic signed [15:0] temp, input logic [3:0] idx = 0,
			input logic [10:0] tgt = 0, input logic fast = 0,
			input logic [31:0] ramp = 0, input logic [31:0] dwell = 0);
		int gap;
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1;
		req.req_type <= kind;
		req.now_ms <= now;
		req.measured_temp <= temp;
		req.entry_index <= idx;
		req.entry_target <= tgt;
		req.entry_fast <= fast;
		req.entry_ramp_ms <= ramp;
		req.entry_dwell_ms <= dwell;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	task automatic settle_and_set(input logic [4:0] count);
		req.valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (80) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic tick();
		logic signed [15:0] temp;
		if ($urandom_range(0, 40) == 0)
			clock_ms = $urandom;
		else
			clock_ms += $urandom_range(0, 900);
		temp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32767));
		send(REQ_TICK, clock_ms, temp);
	endtask

	task automatic load_step(input logic [3:0] idx);
		logic [31:0] ramp, dwell;
		ramp = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3000);
		dwell = ($urandom_range(0, 15) == 0) ? $urandom :
			($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2000);
		send(REQ_WRITE, $urandom, 16'($urandom), idx, 11'($urandom),
			$urandom_range(0, 3) == 0, ramp, dwell);
	endtask

	// one program: reload some steps, start, tick through it with a little noise
	task automatic run_program();
		int k, n;
		k = $urandom_range(0, 4);
		repeat (k) load_step(4'($urandom));
		clock_ms += $urandom_range(0, 100);
		send(REQ_START, clock_ms, 16'($urandom));
		n = $urandom_range(5, 40);
		repeat (n) begin
			case ($urandom_range(0, 30))
				0: send(REQ_PAUSE, clock_ms, 16'($urandom));
				1: send(REQ_RESUME, clock_ms, 16'($urandom));
				2: send(REQ_STOP, clock_ms, 16'($urandom));
				3: send(REQ_START, clock_ms, 16'($urandom));
				4: load_step(4'($urandom));
				default: tick();
			endcase
		end
		if ($urandom_range(0, 1)) send(REQ_STOP, clock_ms, 16'($urandom));
	endtask

	initial begin
		logic [4:0] counts[6];
		int ph;
		counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// full table with field extremes so no unwritten entry is ever read
		for (int i = 0; i < 16; i++)
			send(REQ_WRITE, 0, 0, 4'(i), (i % 2) ? 11'h7FF : 11'(i * 40), i % 3 == 0,
				(i == 5) ? 32'hFFFF_FFFF : (i == 2 ? 0 : 32'(i * 200)),
				(i == 7) ? 32'hFFFF_FFFF : (i == 4 ? 0 : 32'(i * 100)));
		send(REQ_TICK, 32'd10, 16'sh7FFF);
		send(REQ_PAUSE, 32'd10, 0);
		send(REQ_START, 32'hFFFF_FFF0, -16'sd32768);
		send(REQ_TICK, 32'hFFFF_FFF8, 16'sh7FFF);
		send(REQ_PAUSE, 32'hFFFF_FFF9, 0);
		send(REQ_TICK, 32'hFFFF_FFFF, 0);
		send(REQ_RESUME, 32'hFFFF_FFFF, 0);
		send(REQ_TICK, 32'hFFFF_FFFF, -16'sd1);
		send(REQ_STOP, 32'hFFFF_FFFF, 0);
		send(REQ_STOP, 32'd0, 0);
		clock_ms = 1000;
		ph = 0;
		while (sent < ITEM_GOAL) begin
			settle_and_set((ph < 6) ? counts[ph] : 5'($urandom));
			if (ph == 2) long_hold = 1;
			repeat (4) run_program();
			ph++;
		end
		req.valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("ramp_soak_profile_sequencer verification clean");
		else
			$display("ramp_soak_profile_sequencer verification failed");
		$finish;
	end
endmodule
`default_nettype wire
